// ----- rtl/core/ffea_pkg.sv -----
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and constants for the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

    localparam int EXTENTS   = 64;
    localparam int MIN_BLOCK = 16;
    localparam int AW        = 32;
    // extent lengths need one bit more: a free at address zero can span the
    // whole address space
    localparam int LW        = AW + 1;
    localparam int IDX_W     = $clog2(EXTENTS);
    localparam int CNT_W     = $clog2(EXTENTS + 1);

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_SMALL   = 2'd3;

    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_END    = 2'd1;
    localparam logic [1:0] CFG_GRAN   = 2'd2;

    typedef struct packed {
        logic [1:0]    kind;
        logic [AW-1:0] block_addr;
        logic [AW-1:0] block_size;
    } req_t;

    typedef struct packed {
        logic [AW-1:0] granted_addr;
        logic [AW-1:0] granted_size;
        logic [1:0]    status;
        logic          pool_full;
    } rsp_t;

    // one memory access issued by the sequencer
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [AW-1:0]    wr_base;
        logic [LW-1:0]    wr_len;
    } mem_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ASCAN, S_AWAIT, S_ADEL,
        S_FSCAN, S_FWAIT, S_FPREV, S_FNEXT, S_FMERGE, S_FDEL, S_FINS, S_RESP
    } state_t;

endpackage

// ----- rtl/core/ffea_table.sv -----
// ----------------------------------------------------------------------------
// ffea_table
// Extent table: one synchronous memory of base/length pairs, one read and
// one write port, registered read data.
// ----------------------------------------------------------------------------
module ffea_table import ffea_pkg::*; (
    input  logic          aclk,
    input  mem_cmd_t      cmd,
    output logic [AW-1:0] rd_base,
    output logic [LW-1:0] rd_len
);

    logic [AW+LW-1:0] mem [EXTENTS];
    logic [AW+LW-1:0] rd_reg;

    // write and read the entry pair
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_idx] <= {cmd.wr_base, cmd.wr_len};
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[cmd.rd_idx];
        end
    end

    assign rd_base = rd_reg[AW+LW-1:LW];
    assign rd_len  = rd_reg[LW-1:0];

endmodule

// ----- rtl/core/ffea_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffea_ctrl
// Request sequencer: scans the table, splits, removes, merges and inserts
// extents by read-modify-write through the table memory.
// ----------------------------------------------------------------------------
module ffea_ctrl import ffea_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  req_t          s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rsp_t          m_data,
    input  logic [AW-1:0] pool_start,
    input  logic [AW-1:0] pool_end,
    input  logic [4:0]    granule_log2,
    output mem_cmd_t      cmd,
    input  logic [AW-1:0] rd_base,
    input  logic [LW-1:0] rd_len
);

    localparam logic [AW-1:0] AMAX  = '1;
    localparam logic [AW-1:0] MINB  = AW'(MIN_BLOCK);
    localparam logic [LW-1:0] LMAX  = {1'b0, AMAX};
    localparam logic [LW-1:0] LMINB = {1'b0, MINB};

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [AW-1:0] gm_reg, addr_reg;
    logic [LW-1:0] amt_reg;
    logic [AW-1:0] pb_reg, pb_next;
    logic [LW-1:0] pl_reg, pl_next;
    logic          mp_reg, mp_next;
    logic [AW-1:0] mv_b_reg, mv_b_next;
    logic [LW-1:0] mv_l_reg, mv_l_next;
    logic [AW-1:0] ga_reg, gs_reg, ga_next, gs_next;
    logic [1:0]    st_reg, st_next;
    logic          out_v_reg;
    rsp_t          out_reg;

    // length sum, clamped at the top of the address space
    function automatic logic [LW-1:0] sat_len(logic [LW-1:0] a, logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, LMAX}) ? LMAX : s[LW-1:0];
    endfunction

    // size rounding stayed inside the address space
    function automatic logic sz_ok_r();
        logic [AW-1:0] s;
        s = (req_reg.block_size < MINB) ? MINB : req_reg.block_size;
        return s <= (AMAX - gm_reg);
    endfunction

    // derived per-request values
    logic [4:0]    g;
    logic [AW-1:0] gm, sz, szr, addr_m, room, s0, e0;
    logic [LW-1:0] free_sz, free_amt;
    logic          sz_ok, s_ok;
    always_comb begin
        g = (granule_log2 > 5'd16) ? 5'd16 : granule_log2;
        gm = (AW'(1) << g) - AW'(1);
        sz = (s_data.block_size < MINB) ? MINB : s_data.block_size;
        sz_ok = sz <= (AMAX - gm);
        szr = (sz + gm) & ~gm;
        addr_m = s_data.block_addr & ~gm;
        room = AMAX - addr_m;
        // a size that rounds past the top becomes the full address space
        free_sz = sz_ok ? {1'b0, szr} : {1'b1, AW'(0)};
        free_amt = (free_sz - LW'(1) > {1'b0, room}) ? {1'b0, room} + LW'(1) : free_sz;
        s_ok = pool_start <= (AMAX - gm);
        s0 = (pool_start + gm) & ~gm;
        e0 = pool_end & ~gm;
    end

    logic [AW-1:0] prev_gap, next_gap;
    logic [LW-1:0] sat1, sat2;
    logic          prev_hit, next_hit;
    always_comb begin
        prev_gap = addr_reg - pb_reg;
        next_gap = rd_base - addr_reg;
        prev_hit = mp_reg && ({1'b0, prev_gap} == pl_reg);
        next_hit = {1'b0, next_gap} == amt_reg;
        sat1 = sat_len(pl_reg, amt_reg);
        sat2 = sat_len(sat1, rd_len);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (m_valid && m_ready) out_v_reg <= 1'b0;
            if (state_reg == S_RESP && !out_v_reg) out_v_reg <= 1'b1;
        end
    end

    // request context and work registers
    always_ff @(posedge aclk) begin
        pos_reg <= pos_next; pb_reg <= pb_next; pl_reg <= pl_next;
        mp_reg <= mp_next; mv_b_reg <= mv_b_next; mv_l_reg <= mv_l_next;
        ga_reg <= ga_next; gs_reg <= gs_next; st_reg <= st_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
            gm_reg  <= gm;
            addr_reg <= addr_m;
            amt_reg <= (s_data.kind == KIND_FREE) ? free_amt : {1'b0, szr};
        end
        if (state_reg == S_RESP && !out_v_reg) begin
            out_reg.granted_addr <= ga_reg;
            out_reg.granted_size <= gs_reg;
            out_reg.status       <= st_reg;
            out_reg.pool_full    <= (cnt_reg == '0);
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; pos_next = pos_reg;
        pb_next = pb_reg; pl_next = pl_reg; mp_next = mp_reg;
        mv_b_next = mv_b_reg; mv_l_next = mv_l_reg;
        ga_next = ga_reg; gs_next = gs_reg; st_next = st_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = !out_v_reg;
                if (s_valid && !out_v_reg) begin
                    ga_next = '0; gs_next = '0; st_next = ST_OK;
                    pos_next = '0; mp_next = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (req_reg.kind)
                    KIND_ALLOC: begin
                        if (cnt_reg == '0 || !sz_ok_r()) begin
                            st_next = ST_NOFIT; state_next = S_RESP;
                        end else begin
                            cmd.rd_en = 1'b1; cmd.rd_idx = '0;
                            state_next = S_AWAIT;
                        end
                    end
                    KIND_FREE: begin
                        if (cnt_reg == '0) state_next = S_FINS;
                        else begin
                            cmd.rd_en = 1'b1; cmd.rd_idx = '0;
                            state_next = S_FWAIT;
                        end
                    end
                    KIND_INIT: begin
                        if (!s_ok || e0 < s0 || {1'b0, e0 - s0} < amt_reg || !sz_ok_r()) begin
                            st_next = ST_SMALL;
                        end else begin
                            cmd.wr_en = 1'b1; cmd.wr_idx = '0;
                            cmd.wr_base = s0; cmd.wr_len = {1'b0, e0 - s0};
                            cnt_next = CNT_W'(1);
                        end
                        state_next = S_RESP;
                    end
                    default: state_next = S_RESP;
                endcase
            end
            // alloc: rd data holds entry pos_reg
            S_AWAIT: begin
                if (rd_len >= amt_reg) begin
                    ga_next = rd_base;
                    if (rd_len - amt_reg >= LMINB) begin
                        gs_next = amt_reg[AW-1:0];
                        cmd.wr_en = 1'b1; cmd.wr_idx = pos_reg[IDX_W-1:0];
                        cmd.wr_base = rd_base + amt_reg[AW-1:0];
                        cmd.wr_len = rd_len - amt_reg;
                        state_next = S_RESP;
                    end else begin
                        gs_next = rd_len[AW-1:0];
                        state_next = S_ADEL;
                    end
                end else if (pos_reg + CNT_W'(1) >= cnt_reg) begin
                    st_next = ST_NOFIT; state_next = S_RESP;
                end else begin
                    pos_next = pos_reg + CNT_W'(1);
                    cmd.rd_en = 1'b1; cmd.rd_idx = IDX_W'(pos_reg + CNT_W'(1));
                    state_next = S_AWAIT;
                end
            end
            S_ADEL, S_FDEL: begin
                // shift entries above pos_reg down by one
                if (pos_reg + CNT_W'(1) >= cnt_reg) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    state_next = S_RESP;
                end else begin
                    cmd.rd_en = 1'b1; cmd.rd_idx = IDX_W'(pos_reg + CNT_W'(1));
                    state_next = S_ASCAN;
                end
            end
            S_ASCAN: begin
                cmd.wr_en = 1'b1; cmd.wr_idx = pos_reg[IDX_W-1:0];
                cmd.wr_base = rd_base; cmd.wr_len = rd_len;
                pos_next = pos_reg + CNT_W'(1);
                state_next = S_ADEL;
            end
            // free: scan for first base above addr
            S_FWAIT: begin
                if (rd_base <= addr_reg) begin
                    pb_next = rd_base; pl_next = rd_len;
                    mp_next = 1'b1;
                    if (pos_reg + CNT_W'(1) >= cnt_reg) begin
                        pos_next = cnt_reg;
                        state_next = S_FPREV;
                    end else begin
                        pos_next = pos_reg + CNT_W'(1);
                        cmd.rd_en = 1'b1; cmd.rd_idx = IDX_W'(pos_reg + CNT_W'(1));
                    end
                end else begin
                    state_next = S_FNEXT;
                end
            end
            // no next entry
            S_FPREV: begin
                if (prev_hit) begin
                    cmd.wr_en = 1'b1; cmd.wr_idx = IDX_W'(pos_reg - CNT_W'(1));
                    cmd.wr_base = pb_reg; cmd.wr_len = sat1;
                    state_next = S_RESP;
                end else state_next = S_FINS;
            end
            // rd holds entry pos_reg (next)
            S_FNEXT: begin
                if (prev_hit) begin
                    cmd.wr_en = 1'b1; cmd.wr_idx = IDX_W'(pos_reg - CNT_W'(1));
                    cmd.wr_base = pb_reg;
                    if (next_hit) begin
                        cmd.wr_len = sat2;
                        state_next = S_FDEL;
                    end else begin
                        cmd.wr_len = sat1;
                        state_next = S_RESP;
                    end
                end else if (next_hit) begin
                    cmd.wr_en = 1'b1; cmd.wr_idx = pos_reg[IDX_W-1:0];
                    cmd.wr_base = addr_reg;
                    cmd.wr_len = sat_len(rd_len, amt_reg);
                    state_next = S_RESP;
                end else state_next = S_FINS;
            end
            // insert at pos_reg, rippling the entries from pos_reg up by one
            S_FINS: begin
                if (cnt_reg >= CNT_W'(EXTENTS)) begin
                    st_next = ST_FULL; state_next = S_RESP;
                end else begin
                    mv_b_next = addr_reg; mv_l_next = amt_reg;
                    if (pos_reg == cnt_reg) begin
                        cmd.wr_en = 1'b1; cmd.wr_idx = pos_reg[IDX_W-1:0];
                        cmd.wr_base = addr_reg; cmd.wr_len = amt_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                        state_next = S_RESP;
                    end else begin
                        cmd.rd_en = 1'b1; cmd.rd_idx = pos_reg[IDX_W-1:0];
                        state_next = S_FMERGE;
                    end
                end
            end
            // ripple: write carried pair, pick up the displaced one
            S_FMERGE: begin
                cmd.wr_en = 1'b1; cmd.wr_idx = pos_reg[IDX_W-1:0];
                cmd.wr_base = mv_b_reg; cmd.wr_len = mv_l_reg;
                mv_b_next = rd_base; mv_l_next = rd_len;
                pos_next = pos_reg + CNT_W'(1);
                if (pos_reg + CNT_W'(1) == cnt_reg) begin
                    state_next = S_FSCAN;
                end else begin
                    cmd.rd_en = 1'b1; cmd.rd_idx = IDX_W'(pos_reg + CNT_W'(1));
                end
            end
            S_FSCAN: begin
                cmd.wr_en = 1'b1; cmd.wr_idx = pos_reg[IDX_W-1:0];
                cmd.wr_base = mv_b_reg; cmd.wr_len = mv_l_reg;
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!out_v_reg) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

// ----- rtl/core/first_fit_extent_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// Sorted free-extent table with first-fit allocation and coalescing free.
// ----------------------------------------------------------------------------
// One request at a time. Alloc and free scan the sorted table entry by entry
// through the single table memory; a remove shifts each entry above the
// removed one down with a read and then a write, and an insert ripples the
// entries from the insert point up by one. The table holds up to 64 entries.
// Result is held in an output register; the next request is taken once it
// has been delivered.
module first_fit_extent_allocator import ffea_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  req_t          s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rsp_t          m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    logic [AW-1:0] pool_start_reg, pool_end_reg;
    logic [4:0]    gran_reg;
    mem_cmd_t      cmd;
    logic [AW-1:0] rd_base;
    logic [LW-1:0] rd_len;

    assign cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_start_reg <= '0;
            pool_end_reg   <= '0;
            gran_reg       <= 5'd2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START: pool_start_reg <= cfg_data;
                CFG_END:   pool_end_reg   <= cfg_data;
                CFG_GRAN:  gran_reg       <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    ffea_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .pool_start(pool_start_reg), .pool_end(pool_end_reg),
        .granule_log2(gran_reg), .cmd, .rd_base, .rd_len
    );

    ffea_table u_table (.aclk, .cmd, .rd_base, .rd_len);

endmodule
